[sv/bqce_pkg.sv]
// ----------------------------------------------------------------------------
// bqce_pkg
// Shared constants, types and the sine table of the billboard corner expander.
// ----------------------------------------------------------------------------
package bqce_pkg;

	localparam int ANGLE_TABLE_BITS = 10;
	localparam int TBL_DEPTH        = 1 << ANGLE_TABLE_BITS;

	localparam logic [1:0] REG_SCALE_X = 2'd0;
	localparam logic [1:0] REG_SCALE_Y = 2'd1;
	localparam logic [1:0] REG_FIXED   = 2'd2;

	localparam logic [63:0] Q30_C1 = 64'd1686629713;
	localparam logic [63:0] Q30_C3 = 64'd693598668;
	localparam logic [63:0] Q30_C5 = 64'd85569306;
	localparam logic [63:0] Q30_C7 = 64'd5026995;
	localparam logic [63:0] Q30_C9 = 64'd172272;

	// quarter-wave sine, Q16, r in 0..16384 (evaluated at elaboration only)
	function automatic logic [16:0] quarter_sin(input logic [14:0] r);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] p;
		logic [63:0] s;
		t  = {33'd0, r, 16'd0};
		t2 = (t * t) >> 30;
		p  = Q30_C9;
		p  = Q30_C7 - ((p * t2) >> 30);
		p  = Q30_C5 - ((p * t2) >> 30);
		p  = Q30_C3 - ((p * t2) >> 30);
		p  = Q30_C1 - ((p * t2) >> 30);
		s  = (p * t) >> 30;
		s  = (s + 64'd8192) >> 14;
		if (s > 64'd65536)
			s = 64'd65536;
		return s[16:0];
	endfunction

	// signed Q1.16 needs 18 bits to hold both +1.0 and -1.0
	typedef logic [17:0] sin_tbl_t [TBL_DEPTH];

	function automatic sin_tbl_t build_sin_tbl();
		sin_tbl_t tb;
		logic [15:0] a;
		logic [13:0] rr;
		logic [17:0] m;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			a  = 16'(i << (16 - ANGLE_TABLE_BITS));
			rr = a[13:0];
			if (a[14])
				m = {1'b0, quarter_sin(15'd16384 - {1'b0, rr})};
			else
				m = {1'b0, quarter_sin({1'b0, rr})};
			tb[i] = a[15] ? (~m + 18'd1) : m;
		end
		return tb;
	endfunction

	localparam sin_tbl_t SIN_TBL = build_sin_tbl();

	typedef struct packed {
		logic [23:0] scale_x;
		logic [23:0] scale_y;
		logic        fixed;
	} cfg_t;

	typedef struct packed {
		logic signed [23:0] u_min;
		logic signed [23:0] v_min;
		logic signed [23:0] u_max;
		logic signed [23:0] v_max;
	} uv_t;

	// four rotated products, Q.32, signed
	typedef struct packed {
		logic signed [58:0] xc;
		logic signed [58:0] xs;
		logic signed [58:0] yc;
		logic signed [58:0] ys;
	} prod_t;

endpackage

[sv/bqce_front.sv]
// ----------------------------------------------------------------------------
// bqce_front
// Extent scaling and rotation: three pipeline stages, stall-aware.
// ----------------------------------------------------------------------------
module bqce_front import bqce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_v,
	input  cfg_t        cfg,
	input  logic [23:0] half_width,
	input  logic [23:0] half_height,
	input  logic [23:0] screen_factor,
	input  logic [15:0] angle,
	input  uv_t         uv_in,
	output logic        v_out,
	output prod_t       prod,
	output uv_t         uv_out
);
	logic [ANGLE_TABLE_BITS-1:0] ai;
	logic [47:0] mx, my;
	logic [39:0] sx_s1, sy_s1, sx_s2, sy_s2;
	logic [23:0] sf_s1;
	logic        fx_s1;
	logic signed [17:0] s_s1, c_s1, s_s2, c_s2;
	logic [63:0] fxm, fym;
	uv_t uv_s1, uv_s2, uv_s3;
	logic v_s1, v_s2, v_s3;
	prod_t pr_s3;

	assign ai = angle[15 -: ANGLE_TABLE_BITS];
	assign mx = {24'd0, half_width} * {24'd0, cfg.scale_x};
	assign my = {24'd0, half_height} * {24'd0, cfg.scale_y};
	assign fxm = {24'd0, sx_s1} * {40'd0, sf_s1};
	assign fym = {24'd0, sy_s1} * {40'd0, sf_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1 <= {8'd0, mx[47:16]};
			sy_s1 <= {8'd0, my[47:16]};
			sf_s1 <= screen_factor;
			fx_s1 <= cfg.fixed;
			s_s1  <= SIN_TBL[ai];
			c_s1  <= SIN_TBL[ai + ANGLE_TABLE_BITS'(TBL_DEPTH / 4)];
			uv_s1 <= uv_in;
			sx_s2 <= fx_s1 ? fxm[55:16] : sx_s1;
			sy_s2 <= fx_s1 ? fym[55:16] : sy_s1;
			s_s2  <= s_s1;
			c_s2  <= c_s1;
			uv_s2 <= uv_s1;
			pr_s3.xc <= $signed({1'b0, sx_s2}) * c_s2;
			pr_s3.xs <= $signed({1'b0, sx_s2}) * s_s2;
			pr_s3.yc <= $signed({1'b0, sy_s2}) * c_s2;
			pr_s3.ys <= $signed({1'b0, sy_s2}) * s_s2;
			uv_s3 <= uv_s2;
		end
	end

	assign v_out  = v_s3;
	assign prod   = pr_s3;
	assign uv_out = uv_s3;
endmodule

[sv/bqce_corner.sv]
// ----------------------------------------------------------------------------
// bqce_corner
// Corner sum, floor shift and saturation for one selected corner.
// ----------------------------------------------------------------------------
module bqce_corner import bqce_pkg::*; (
	input  prod_t              prod,
	input  logic [1:0]         k,
	output logic signed [31:0] ox,
	output logic signed [31:0] oy
);
	logic signed [59:0] sxv, syv;
	logic signed [43:0] fx, fy;

	function automatic logic signed [31:0] sat(input logic signed [43:0] v);
		if (v > 44'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -44'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	always_comb begin
		case (k)
			2'd0: begin
				sxv = -prod.xc + prod.ys;
				syv =  prod.xs + prod.yc;
			end
			2'd1: begin
				sxv =  prod.xc + prod.ys;
				syv = -prod.xs + prod.yc;
			end
			2'd2: begin
				sxv =  prod.xc - prod.ys;
				syv = -prod.xs - prod.yc;
			end
			default: begin
				sxv = -prod.xc - prod.ys;
				syv =  prod.xs - prod.yc;
			end
		endcase
	end

	// arithmetic shift floors toward minus infinity
	assign fx = sxv[59:16];
	assign fy = syv[59:16];
	assign ox = sat(fx);
	assign oy = sat(fy);
endmodule

[sv/billboard_quad_corner_expand.sv]
// ----------------------------------------------------------------------------
// billboard_quad_corner_expand
// Expands one billboard into its four rotated, saturated quad corners.
// ----------------------------------------------------------------------------
// An input passes the front stages, then the hold register, to corner 0; corners
// follow one per cycle on the single corner output port unless out_stall is high.
// The hold register emits the current quad; the front pipe stalls while its
// last stage waits for the hold register to free up.
// Reset clears valid bits and loads scale 1.0, fixed screen mode off.
module billboard_quad_corner_expand import bqce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [23:0]        half_width,
	input  logic [23:0]        half_height,
	input  logic [23:0]        screen_factor,
	input  logic [15:0]        angle,
	input  logic signed [23:0] u_min,
	input  logic signed [23:0] v_min,
	input  logic signed [23:0] u_max,
	input  logic signed [23:0] v_max,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         corner,
	output logic signed [31:0] offset_x,
	output logic signed [31:0] offset_y,
	output logic signed [23:0] tex_u,
	output logic signed [23:0] tex_v,
	output logic               last
);
	cfg_t  cfg_q;
	logic  adv, fv;
	prod_t fprod, hp_q;
	uv_t   fuv, huv_q;
	logic  hv_q, ex_load, ex_done;
	logic  [1:0] k_q;
	logic  ov_q;
	logic signed [31:0] cx, cy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_x <= 24'd65536;
			cfg_q.scale_y <= 24'd65536;
			cfg_q.fixed   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE_X: cfg_q.scale_x <= cfg_data;
				REG_SCALE_Y: cfg_q.scale_y <= cfg_data;
				REG_FIXED:   cfg_q.fixed   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// hold register: emits corners of the current quad
	assign ex_done = ov_q && !out_stall && (k_q == 2'd3);
	assign ex_load = fv && (!hv_q || ex_done);

	// front pipe advances when its last stage is empty or moves into the hold
	assign adv      = !fv || ex_load;
	assign in_stall = !adv;

	bqce_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_v(in_valid), .cfg(cfg_q),
		.half_width(half_width), .half_height(half_height),
		.screen_factor(screen_factor), .angle(angle),
		.uv_in('{u_min: u_min, v_min: v_min, u_max: u_max, v_max: v_max}),
		.v_out(fv), .prod(fprod), .uv_out(fuv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			k_q  <= 2'd0;
			ov_q <= 1'b0;
		end else begin
			if (ex_load) begin
				hv_q <= 1'b1;
			end else if (ex_done) begin
				hv_q <= 1'b0;
			end
			if (ov_q && !out_stall)
				k_q <= k_q + 2'd1;
			ov_q <= ex_load || (hv_q && !ex_done);
		end
	end

	always_ff @(posedge clk) begin
		if (ex_load) begin
			hp_q  <= fprod;
			huv_q <= fuv;
		end
	end

	bqce_corner u_corner (.prod(hp_q), .k(k_q), .ox(cx), .oy(cy));

	assign out_valid = ov_q;
	assign corner    = k_q;
	assign offset_x  = cx;
	assign offset_y  = cy;
	assign tex_u     = (k_q == 2'd1 || k_q == 2'd2) ? huv_q.u_max : huv_q.u_min;
	assign tex_v     = k_q[1] ? huv_q.v_max : huv_q.v_min;
	assign last      = (k_q == 2'd3);

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (corner == 2'd3)))
		else $error("last flag off corner three");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(corner)))
		else $error("corner moved under stall");
	a_ov: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid == hv_q)
		else $error("output valid out of step with hold register");
endmodule
